// ===== src/hte_pkg.sv =====
package hte_pkg;

   localparam int DEF_MAX_COLS    = 256;
   localparam int DEF_MAX_ROWS    = 256;
   localparam int DEF_HEIGHT_BITS = 16;

   localparam int REQ_TYPE_W   = 2;
   localparam int CELL_INDEX_W = 16;
   localparam int HEIGHT_IO_W  = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 9;
   localparam int DIM_REG_W    = 9;
   localparam int PASS_REG_W   = 8;

   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RUN   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_COUNT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_MODE = 2'd3;

   localparam logic [DIM_REG_W-1:0]  RST_GRID_WIDTH  = 9'd256;
   localparam logic [DIM_REG_W-1:0]  RST_GRID_HEIGHT = 9'd256;
   localparam logic [PASS_REG_W-1:0] RST_PASS_COUNT  = 8'd1;

   // talus limits in units of one full height step
   localparam int TALUS_ABOVE = 4;
   localparam int TALUS_BELOW = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_RUN,
      ST_CUR,
      ST_SCAN,
      ST_MUL,
      ST_TEST,
      ST_TWR
   } state_type;

   typedef enum logic [1:0] {
      TAG_NONE,
      TAG_CUR,
      TAG_NB
   } tag_type;

   typedef struct packed {
      logic better;
      logic talus_pass;
   } alu_flags_type;

endpackage

// ===== src/heightmap_thermal_erosion.sv =====
// Thermal erosion engine over a height map held in an internal store.
// Channels: req_* carries one item (write cell, run sweeps, read cell), rsp_* returns
// exactly one item per request, csr_* writes the geometry, pass count and talus mode.
// csr_ready is always high; write registers only while no request is outstanding.
// Write items and rejected (out of range) items: result registered one cycle after
// acceptance, and a new item is taken every cycle while the receiver keeps up.
// Read items: data passes the registered store read port, then the output register.
// Run items: each cell steps through the states CUR, SCAN, MUL and TEST, and TWR when
// material moves (one store access per cycle through the single store port: cell,
// up to four neighbors, the cell write and the neighbor write, plus the multiply and
// talus compare steps of the shared unit). A run sweeps every cell pass_count times,
// and its result item follows the last sweep.
// The block holds req_ready low while a result waits in the output register and the
// receiver stalls, and for the whole of a read or a run.
// Reset (synchronous, active high) clears the control state and restores the
// register defaults; the store itself is not cleared and must be written before use.
module heightmap_thermal_erosion import hte_pkg::*; #(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [REQ_TYPE_W-1:0]   req_type,
   input  logic [CELL_INDEX_W-1:0] req_cell_index,
   input  logic [HEIGHT_IO_W-1:0]  req_height_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [HEIGHT_IO_W-1:0]  rsp_height_out,
   output logic                    rsp_index_error,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CW      = $clog2(MAX_COLS);
   localparam int RW      = $clog2(MAX_ROWS);
   localparam int WW      = $clog2(MAX_COLS + 1);
   localparam int HW      = $clog2(MAX_ROWS + 1);
   localparam int DEPTH   = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PROD_W  = HEIGHT_BITS + WW;
   localparam int CELLS_W = WW + HW;
   localparam logic [2:0] NB_COUNT = 3'd4;

   logic [DIM_REG_W-1:0]   grid_width_ff;
   logic [DIM_REG_W-1:0]   grid_height_ff;
   logic [PASS_REG_W-1:0]  pass_count_ff;
   logic                   inverse_mode_ff;

   state_type              state_ff, state_in;
   tag_type                tag_ff, tag_in;
   logic [2:0]             k_ff;
   logic [ADDR_W-1:0]      me_ff;
   logic [CW-1:0]          col_ff;
   logic [RW-1:0]          row_ff;
   logic [PASS_REG_W-1:0]  pass_ff;
   logic [HEIGHT_BITS-1:0] cur_ff;
   logic [HEIGHT_BITS-1:0] best_ff;
   logic [ADDR_W-1:0]      target_ff;
   logic [ADDR_W-1:0]      nbaddr_q_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic                   rsp_valid_ff;
   logic [HEIGHT_IO_W-1:0] rsp_height_ff;
   logic                   rsp_error_ff;

   logic [WW-1:0]          w_eff;
   logic [HW-1:0]          h_eff;
   logic [CELLS_W-1:0]     cells;
   logic                   idx_err;
   logic                   req_acc;
   logic                   nb_inb;
   logic [ADDR_W-1:0]      nb_addr;
   logic                   last_col;
   logic                   last_row;
   logic                   last_pass;
   logic                   sweep_done;
   logic                   advance;
   logic [HEIGHT_BITS-1:0] half;

   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_addr;
   logic [HEIGHT_BITS-1:0] mem_wdata;
   logic [HEIGHT_BITS-1:0] mem_q;

   logic [HEIGHT_BITS-1:0] drop;
   logic [PROD_W-1:0]      prod_next;
   alu_flags_type          flags;

   hte_mem #(
      .DEPTH  (DEPTH),
      .DATA_W (HEIGHT_BITS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_q)
   );

   hte_alu #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .WW          (WW),
      .PROD_W      (PROD_W)
   ) u_alu (
      .cur       (cur_ff),
      .nbr       (mem_q),
      .best      (best_ff),
      .width_eff (w_eff),
      .prod      (prod_ff),
      .inverse   (inverse_mode_ff),
      .drop      (drop),
      .prod_next (prod_next),
      .flags     (flags)
   );

   // clamp geometry to the store's extent; a zero size counts as one
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (grid_width_ff > MAX_COLS) begin
         w_eff = WW'(MAX_COLS);
      end else begin
         w_eff = WW'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (grid_height_ff > MAX_ROWS) begin
         h_eff = HW'(MAX_ROWS);
      end else begin
         h_eff = HW'(grid_height_ff);
      end
   end

   assign cells     = CELLS_W'(w_eff) * CELLS_W'(h_eff);
   assign idx_err   = (32'(req_cell_index) >= 32'(cells));
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign last_col   = (WW'(col_ff) == w_eff - WW'(1));
   assign last_row   = (HW'(row_ff) == h_eff - HW'(1));
   assign last_pass  = (pass_ff == pass_count_ff - PASS_REG_W'(1));
   assign sweep_done = last_col && last_row && last_pass;
   assign advance    = ((state_ff == ST_TEST) && !flags.talus_pass) || (state_ff == ST_TWR);
   assign half       = best_ff >> 1;

   // neighbor order: right, left, down, up
   always_comb begin
      case (k_ff)
         3'd0: begin
            nb_inb  = (WW'(col_ff) + WW'(1)) < w_eff;
            nb_addr = me_ff + ADDR_W'(1);
         end
         3'd1: begin
            nb_inb  = (col_ff != '0);
            nb_addr = me_ff - ADDR_W'(1);
         end
         3'd2: begin
            nb_inb  = (HW'(row_ff) + HW'(1)) < h_eff;
            nb_addr = me_ff + ADDR_W'(w_eff);
         end
         3'd3: begin
            nb_inb  = (row_ff != '0);
            nb_addr = me_ff - ADDR_W'(w_eff);
         end
         default: begin
            nb_inb  = 1'b0;
            nb_addr = me_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_type == REQ_READ && !idx_err) begin
                  state_in = ST_READ;
               end else if (req_type == REQ_RUN) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_RUN: begin
            if (pass_count_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CUR;
            end
         end
         ST_CUR: state_in = ST_SCAN;
         ST_SCAN: begin
            if (k_ff == NB_COUNT) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_TEST;
         ST_TEST: begin
            if (flags.talus_pass) begin
               state_in = ST_TWR;
            end else if (sweep_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CUR;
            end
         end
         ST_TWR: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CUR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // store port: one access per cycle
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = me_ff;
      mem_wdata = cur_ff - half;
      unique case (state_ff)
         ST_IDLE: begin
            mem_addr  = ADDR_W'(req_cell_index);
            mem_wdata = HEIGHT_BITS'(req_height_in);
            mem_we    = req_acc && (req_type == REQ_WRITE) && !idx_err;
         end
         ST_SCAN: begin
            mem_addr = nb_addr;
         end
         ST_TEST: begin
            mem_we = flags.talus_pass;
         end
         ST_TWR: begin
            // the target held cur - best when scanned and has not changed since
            mem_we    = 1'b1;
            mem_addr  = target_ff;
            mem_wdata = cur_ff - best_ff + half;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      tag_in = TAG_NONE;
      if (state_ff == ST_CUR) begin
         tag_in = TAG_CUR;
      end else if (state_ff == ST_SCAN && k_ff != NB_COUNT && nb_inb) begin
         tag_in = TAG_NB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tag_ff          <= TAG_NONE;
         rsp_valid_ff    <= 1'b0;
         grid_width_ff   <= RST_GRID_WIDTH;
         grid_height_ff  <= RST_GRID_HEIGHT;
         pass_count_ff   <= RST_PASS_COUNT;
         inverse_mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:   grid_width_ff   <= csr_data;
               CSR_GRID_HEIGHT:  grid_height_ff  <= csr_data;
               CSR_PASS_COUNT:   pass_count_ff   <= csr_data[PASS_REG_W-1:0];
               CSR_INVERSE_MODE: inverse_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if ((req_acc && !(req_type == REQ_RUN) && !(req_type == REQ_READ && !idx_err))
               || (state_ff == ST_READ)
               || (state_ff == ST_RUN && pass_count_ff == '0)
               || (advance && sweep_done)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_acc) begin
         rsp_height_ff <= '0;
         rsp_error_ff  <= ((req_type == REQ_WRITE) || (req_type == REQ_READ)) && idx_err;
      end else if (state_ff == ST_READ) begin
         rsp_height_ff <= HEIGHT_IO_W'(mem_q);
         rsp_error_ff  <= 1'b0;
      end else if (state_ff == ST_RUN) begin
         rsp_height_ff <= '0;
         rsp_error_ff  <= 1'b0;
      end

      if (state_ff == ST_RUN) begin
         col_ff  <= '0;
         row_ff  <= '0;
         me_ff   <= '0;
         pass_ff <= '0;
      end else if (advance) begin
         if (last_col) begin
            col_ff <= '0;
            if (last_row) begin
               row_ff  <= '0;
               me_ff   <= '0;
               pass_ff <= pass_ff + PASS_REG_W'(1);
            end else begin
               row_ff <= row_ff + RW'(1);
               me_ff  <= me_ff + ADDR_W'(1);
            end
         end else begin
            col_ff <= col_ff + CW'(1);
            me_ff  <= me_ff + ADDR_W'(1);
         end
      end

      if (state_ff == ST_CUR) begin
         k_ff    <= '0;
         best_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (k_ff != NB_COUNT) begin
            k_ff        <= k_ff + 3'd1;
            nbaddr_q_ff <= nb_addr;
         end
         if (tag_ff == TAG_CUR) begin
            cur_ff <= mem_q;
         end else if (tag_ff == TAG_NB && flags.better) begin
            best_ff   <= drop;
            target_ff <= nbaddr_q_ff;
         end
      end

      if (state_ff == ST_MUL) begin
         prod_ff <= prod_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_height_out  = rsp_height_ff;
   assign rsp_index_error = rsp_error_ff;

endmodule

// ===== src/hte_mem.sv =====
module hte_mem import hte_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
   parameter int DATA_W = DEF_HEIGHT_BITS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/hte_alu.sv =====
module hte_alu import hte_pkg::*; #(
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
   parameter int WW          = $clog2(DEF_MAX_COLS + 1),
   parameter int PROD_W      = HEIGHT_BITS + WW
) (
   input  logic [HEIGHT_BITS-1:0] cur,
   input  logic [HEIGHT_BITS-1:0] nbr,
   input  logic [HEIGHT_BITS-1:0] best,
   input  logic [WW-1:0]          width_eff,
   input  logic [PROD_W-1:0]      prod,
   input  logic                   inverse,
   output logic [HEIGHT_BITS-1:0] drop,
   output logic [PROD_W-1:0]      prod_next,
   output alu_flags_type          flags
);

   localparam int CMP_W = PROD_W + 4;
   localparam logic [CMP_W-1:0] LIMIT_ABOVE = CMP_W'(TALUS_ABOVE) << HEIGHT_BITS;
   localparam logic [CMP_W-1:0] LIMIT_BELOW = CMP_W'(TALUS_BELOW) << HEIGHT_BITS;

   logic [CMP_W-1:0] prod_ext;

   assign drop      = cur - nbr;
   assign prod_next = PROD_W'(best) * PROD_W'(width_eff);
   assign prod_ext  = CMP_W'(prod);

   always_comb begin
      flags.better = (cur > nbr) && (drop > best);
      if (best == '0) begin
         flags.talus_pass = 1'b0;
      end else if (inverse) begin
         flags.talus_pass = (prod_ext <= LIMIT_BELOW);
      end else begin
         flags.talus_pass = (prod_ext > LIMIT_ABOVE);
      end
   end

endmodule
